FILE: src/imf_pkg.sv
// ----------------------------------------------------------------------------
// imf_pkg
// Shared types and codes for the inverter mode and fault controller.
// ----------------------------------------------------------------------------
package imf_pkg;

  localparam int MODE_W  = 3;
  localparam int CMD_W   = 3;
  localparam int CTL_W   = 3;
  localparam int IDX_W   = 8;
  localparam int FLAGS_W = 8;
  localparam int EVT_W   = 16;
  localparam int TICK_W  = 17;
  localparam int HOLD_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [MODE_W-1:0] MODE_INIT     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_START    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RUN      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SHUTDOWN = 3'd4;

  localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CONTROL   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET_FAULT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLR_FAULT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLR_ALL   = 3'd4;

  localparam logic [CTL_W-1:0] CTL_NONE     = 3'd0;
  localparam logic [CTL_W-1:0] CTL_START    = 3'd1;
  localparam logic [CTL_W-1:0] CTL_STOP     = 3'd2;
  localparam logic [CTL_W-1:0] CTL_SHUTDOWN = 3'd3;
  localparam logic [CTL_W-1:0] CTL_RECOVER  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_FAULT_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_HOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_HOLD = 2'd2;

  localparam logic [FLAGS_W-1:0] FAULT_MASK_RST = 8'hFF;
  localparam logic [HOLD_W-1:0]  INIT_HOLD_RST  = 16'd100;
  localparam logic [HOLD_W-1:0]  START_HOLD_RST = 16'd50;
  localparam logic [TICK_W-1:0]  TICKS_MAX      = 17'h1FFFF;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [CTL_W-1:0] control_cmd;
    logic [IDX_W-1:0] fault_index;
  } imf_item_t;

  typedef struct packed {
    logic [FLAGS_W-1:0] fault_enable_mask;
    logic [HOLD_W-1:0]  init_hold_ticks;
    logic [HOLD_W-1:0]  start_hold_ticks;
  } imf_cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [MODE_W-1:0]  prior_mode;
    logic               fault_active;
    logic [FLAGS_W-1:0] fault_flags;
    logic [EVT_W-1:0]   fault_events;
    logic               running;
    logic [TICK_W-1:0]  ticks_in_mode;
  } imf_status_t;

  // Target mode of one control command; equal to the current mode when
  // the command causes no move.
  function automatic logic [MODE_W-1:0] ctl_target(input logic [MODE_W-1:0] mode,
                                                   input logic [CTL_W-1:0]  ctl,
                                                   input logic              flt);
    logic [MODE_W-1:0] tgt;
    tgt = mode;
    unique case (mode) inside
      MODE_INIT: begin
        if (ctl == CTL_NONE && !flt) tgt = MODE_IDLE;
      end
      MODE_IDLE: begin
        if (ctl == CTL_START) begin
          if (!flt) tgt = MODE_START;
        end else if (ctl == CTL_SHUTDOWN || flt) begin
          tgt = MODE_SHUTDOWN;
        end
      end
      MODE_START, MODE_RUN: begin
        if (ctl == CTL_STOP || ctl == CTL_SHUTDOWN || flt) tgt = MODE_SHUTDOWN;
      end
      MODE_SHUTDOWN: begin
        if (ctl == CTL_RECOVER) tgt = MODE_RUN;
        else if (ctl == CTL_START) tgt = MODE_START;
      end
      default: tgt = mode;
    endcase
    return tgt;
  endfunction

endpackage

FILE: src/inverter_mode_fault_fsm_core.sv
// ----------------------------------------------------------------------------
// inverter_mode_fault_fsm_core
// Inverter mode controller with fault flags, one status word per event.
// ----------------------------------------------------------------------------
// Each accepted event word produces exactly one status word, reporting the
// state after that event. An event passes through an input register and the
// state update logic into the output register, so the block sustains one
// word per cycle while the output is not stalled. Output stall backs up
// through the input register. Configuration writes take effect at once and
// are meant to be made while no event is in flight.
module inverter_mode_fault_fsm_core #(
  parameter int FAULT_COUNT = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [imf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [imf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [imf_pkg::CMD_W-1:0]       in_command,
  input  logic [imf_pkg::CTL_W-1:0]       in_control_cmd,
  input  logic [imf_pkg::IDX_W-1:0]       in_fault_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [imf_pkg::MODE_W-1:0]      out_mode,
  output logic [imf_pkg::MODE_W-1:0]      out_prior_mode,
  output logic                            out_fault_active,
  output logic [imf_pkg::FLAGS_W-1:0]     out_fault_flags,
  output logic [imf_pkg::EVT_W-1:0]       out_fault_events,
  output logic                            out_running,
  output logic [imf_pkg::TICK_W-1:0]      out_ticks_in_mode
);
  import imf_pkg::*;

  imf_cfg_t    cfg_r;
  imf_item_t   in_item, s1_item;
  imf_status_t status_nxt, status_r;
  logic        s1_valid, advance;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fault_enable_mask <= FAULT_MASK_RST;
      cfg_r.init_hold_ticks   <= INIT_HOLD_RST;
      cfg_r.start_hold_ticks  <= START_HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FAULT_MASK: cfg_r.fault_enable_mask <= cfg_data[FLAGS_W-1:0];
        REG_INIT_HOLD:  cfg_r.init_hold_ticks   <= cfg_data[HOLD_W-1:0];
        REG_START_HOLD: cfg_r.start_hold_ticks  <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_item.command     = in_command;
  assign in_item.control_cmd = in_control_cmd;
  assign in_item.fault_index = in_fault_index;

  // The queued word moves on when the output register is empty or its
  // word is being taken.
  assign advance = s1_valid && (!out_valid_r || !out_stall);

  imf_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  imf_core #(
    .FAULT_COUNT (FAULT_COUNT)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .commit     (advance),
    .item       (s1_item),
    .cfg        (cfg_r),
    .status_nxt (status_nxt)
  );

  assign out_valid_nxt = advance ? 1'b1 : ((out_valid_r && out_stall) ? 1'b1 : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status_r <= status_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_mode          = status_r.mode;
  assign out_prior_mode    = status_r.prior_mode;
  assign out_fault_active  = status_r.fault_active;
  assign out_fault_flags   = status_r.fault_flags;
  assign out_fault_events  = status_r.fault_events;
  assign out_running       = status_r.running;
  assign out_ticks_in_mode = status_r.ticks_in_mode;

endmodule

FILE: src/imf_in_reg.sv
// ----------------------------------------------------------------------------
// imf_in_reg
// Input register stage: holds one accepted word until the core takes it.
// ----------------------------------------------------------------------------
module imf_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  imf_pkg::imf_item_t in_item,
  input  logic               advance,
  output logic               s1_valid,
  output imf_pkg::imf_item_t s1_item
);
  import imf_pkg::*;

  logic      valid_r, valid_nxt;
  imf_item_t item_r;
  logic      load;

  // The stage can take a word whenever it is empty or is handing its
  // word on in this same cycle.
  assign in_stall  = valid_r && !advance;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

FILE: src/imf_core.sv
// ----------------------------------------------------------------------------
// imf_core
// Mode state machine, tick counter, fault flags and fault event counter.
// ----------------------------------------------------------------------------
module imf_core #(
  parameter int FAULT_COUNT = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 commit,
  input  imf_pkg::imf_item_t   item,
  input  imf_pkg::imf_cfg_t    cfg,
  output imf_pkg::imf_status_t status_nxt
);
  import imf_pkg::*;

  logic [MODE_W-1:0]      mode_r, mode_nxt;
  logic [MODE_W-1:0]      prior_r, prior_nxt;
  logic [TICK_W-1:0]      ticks_r, ticks_nxt;
  logic [FAULT_COUNT-1:0] fault_r, fault_nxt;
  logic [EVT_W-1:0]       events_r, events_nxt;

  logic [FLAGS_W-1:0] flags_cur, flags_new;
  logic               flt_cur;
  logic               idx_ok;
  logic [TICK_W-1:0]  ticks_inc;
  logic [TICK_W-1:0]  ticks_keep;
  logic [MODE_W-1:0]  target;

  // Only the low eight flags are visible and can be enabled.
  for (genvar i = 0; i < FLAGS_W; i++) begin : g_lo
    if (i < FAULT_COUNT) begin : g_on
      assign flags_cur[i] = fault_r[i];
      assign flags_new[i] = fault_nxt[i];
    end else begin : g_off
      assign flags_cur[i] = 1'b0;
      assign flags_new[i] = 1'b0;
    end
  end

  assign flt_cur   = |(flags_cur & cfg.fault_enable_mask);
  assign idx_ok    = item.fault_index < IDX_W'(FAULT_COUNT);
  assign ticks_inc = (ticks_r != TICKS_MAX) ? ticks_r + TICK_W'(1) : ticks_r;

  always_comb begin
    target     = mode_r;
    ticks_keep = ticks_r;
    fault_nxt  = fault_r;
    events_nxt = events_r;
    unique case (item.command)
      CMD_TICK: begin
        ticks_keep = ticks_inc;
        if (mode_r == MODE_INIT) begin
          if (ticks_inc > {1'b0, cfg.init_hold_ticks})
            target = ctl_target(mode_r, CTL_NONE, flt_cur);
        end else if (mode_r == MODE_START) begin
          if (ticks_inc > {1'b0, cfg.start_hold_ticks}) target = MODE_RUN;
        end
      end
      CMD_CONTROL: target = ctl_target(mode_r, item.control_cmd, flt_cur);
      CMD_SET_FAULT: begin
        if (idx_ok) begin
          for (int i = 0; i < FAULT_COUNT; i++) begin
            if (item.fault_index == IDX_W'(i)) fault_nxt[i] = 1'b1;
          end
          events_nxt = events_r + EVT_W'(1);
        end
      end
      CMD_CLR_FAULT: begin
        if (idx_ok) begin
          for (int i = 0; i < FAULT_COUNT; i++) begin
            if (item.fault_index == IDX_W'(i)) fault_nxt[i] = 1'b0;
          end
        end
      end
      CMD_CLR_ALL: fault_nxt = '0;
      default: ;
    endcase
  end

  // A move to the mode already held changes nothing.
  always_comb begin
    if (target != mode_r) begin
      mode_nxt  = target;
      prior_nxt = mode_r;
      ticks_nxt = '0;
    end else begin
      mode_nxt  = mode_r;
      prior_nxt = prior_r;
      ticks_nxt = ticks_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_INIT;
      prior_r  <= MODE_INIT;
      ticks_r  <= '0;
      fault_r  <= '0;
      events_r <= '0;
    end else if (commit) begin
      mode_r   <= mode_nxt;
      prior_r  <= prior_nxt;
      ticks_r  <= ticks_nxt;
      fault_r  <= fault_nxt;
      events_r <= events_nxt;
    end
  end

  always_comb begin
    status_nxt.mode          = mode_nxt;
    status_nxt.prior_mode    = prior_nxt;
    status_nxt.fault_active  = |(flags_new & cfg.fault_enable_mask);
    status_nxt.fault_flags   = flags_new;
    status_nxt.fault_events  = events_nxt;
    status_nxt.running       = (mode_nxt == MODE_RUN);
    status_nxt.ticks_in_mode = ticks_nxt;
  end

endmodule

FILE: src/imf_checker.sv
// ----------------------------------------------------------------------------
// imf_checker
// Port-level checks on the status words of the mode controller.
// ----------------------------------------------------------------------------
module imf_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [imf_pkg::MODE_W-1:0]      out_mode,
  input logic [imf_pkg::MODE_W-1:0]      out_prior_mode,
  input logic                            out_fault_active,
  input logic [imf_pkg::FLAGS_W-1:0]     out_fault_flags,
  input logic [imf_pkg::EVT_W-1:0]       out_fault_events,
  input logic                            out_running,
  input logic [imf_pkg::TICK_W-1:0]      out_ticks_in_mode
);
  import imf_pkg::*;

  // The running flag is just a view of the mode.
  a_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_running == (out_mode == MODE_RUN)))
    else $error("running flag disagrees with mode");

  // An active fault needs at least one raw flag set.
  a_fault_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fault_active) |-> (out_fault_flags != '0))
    else $error("fault active with no flag set");

  // A status word held under stall keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_mode) &&
      $stable(out_prior_mode) && $stable(out_ticks_in_mode) &&
      $stable(out_fault_flags) && $stable(out_fault_events)))
    else $error("status word changed while stalled");

  // A full input stage with a free output register always moves on.
  a_no_stuck: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid && in_stall) |-> 1'b0)
    else $error("input stalled while output register is empty");

endmodule

bind inverter_mode_fault_fsm_core imf_checker u_imf_checker (.*);
